### hdl/vspi_pkg.sv
// Package for the virtual shared-interrupt priority injector: codes, widths, command structs
`timescale 1ns / 1ps
package vspi_pkg;

  localparam int NUM_ENTRIES_DEF   = 32;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 8;
  localparam int MASK_W   = 8;
  localparam int BASE_W   = 10;
  localparam int ID_W     = 11;
  localparam int STATUS_W = 3;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 16;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [MODE_W-1:0] MODE_WR_PRIO    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_PENDING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WR_ENABLE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UPDATE     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INJECTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FORWARDED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FAILED    = 3'd4;

  localparam logic [0:0] REG_INJECT_LIMIT = 1'b0;
  localparam logic [0:0] REG_BASE_ID      = 1'b1;

  localparam logic [MASK_W-1:0] MASK_RESET = 8'd255;
  localparam logic [BASE_W-1:0] BASE_RESET = 10'd32;

  typedef struct packed {
    logic write;
    logic load;
    logic scan_step;
    logic emit;
  } vspi_cmd_t;

  typedef struct packed {
    logic is_update;
    logic needs_select;
    logic scan_last;
    logic out_free;
  } vspi_stat_t;

endpackage

### hdl/virtual_spi_priority_injector.sv
// Items are taken only while idle. A write item gives no result. An update that selects
// scans the entries and then emits its result; any other update goes straight to emit.
// Emit waits until the result register is free, and no new item is taken until the update
// has emitted. The scan compares one entry per cycle; write items one per cycle while idle.
// Reset: synchronous; clears pending, enable, priorities and the asserting flag,
// loads mask 255 and base id 32, and empties the result register.
`timescale 1ns / 1ps
module virtual_spi_priority_injector #(
  parameter int NUM_ENTRIES   = vspi_pkg::NUM_ENTRIES_DEF,
  parameter int PRIORITY_BITS = vspi_pkg::PRIORITY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_index[4:0], write_value[12:5], from_primary[13], list_reg_empty[14],
  // inject_ok[15], event_busy[16], send_ok[17], zero[23:18]
  input  logic [vspi_pkg::IN_W-1:0]     s_axis_tdata,
  // mode[1:0]
  input  logic [vspi_pkg::MODE_W-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // interrupt_id[10:0], zero[15:11]
  output logic [vspi_pkg::OUT_W-1:0]    m_axis_tdata,
  // status[2:0]
  output logic [vspi_pkg::STATUS_W-1:0] m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vspi_pkg::ADDR_W-1:0]   paddr,
  input  logic [vspi_pkg::DATA_W-1:0]   pwdata,
  output logic [vspi_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import vspi_pkg::*;

  logic [MASK_W-1:0] inject_limit;
  logic [BASE_W-1:0] base_interrupt_id;
  vspi_cmd_t         cmd;
  vspi_stat_t        stat;

  vspi_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .inject_limit      (inject_limit),
    .base_interrupt_id (base_interrupt_id)
  );

  vspi_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  vspi_dp #(
    .NUM_ENTRIES   (NUM_ENTRIES),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .inject_limit      (inject_limit),
    .base_interrupt_id (base_interrupt_id),
    .cmd               (cmd),
    .stat              (stat)
  );

  a_update_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_UPDATE)) |=> !s_axis_tready)
    else $error("input still ready after an update transaction");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= ST_FAILED))
    else $error("result status out of range");

  a_no_id_without_pick: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && ((m_axis_tuser == ST_NONE) || (m_axis_tuser == ST_BUSY) ||
                       (m_axis_tuser == ST_FORWARDED))) |-> (m_axis_tdata == '0))
    else $error("interrupt id set on a result without a selected entry");

  a_injected_id: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_INJECTED)) |-> (m_axis_tdata != '0) ||
      (base_interrupt_id == '0))
    else $error("injected result carries a zero id with a non-zero base");

endmodule

### hdl/vspi_cfg.sv
// Configuration registers behind the APB-style port
`timescale 1ns / 1ps
module vspi_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vspi_pkg::ADDR_W-1:0]   paddr,
  input  logic [vspi_pkg::DATA_W-1:0]   pwdata,
  output logic [vspi_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [vspi_pkg::MASK_W-1:0]   inject_limit,
  output logic [vspi_pkg::BASE_W-1:0]   base_interrupt_id
);
  import vspi_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inject_limit      <= MASK_RESET;
      base_interrupt_id <= BASE_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_INJECT_LIMIT) begin
        inject_limit <= pwdata[MASK_W-1:0];
      end else begin
        base_interrupt_id <= pwdata[BASE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_BASE_ID) begin
      prdata = {{(DATA_W-BASE_W){1'b0}}, base_interrupt_id};
    end else begin
      prdata = {{(DATA_W-MASK_W){1'b0}}, inject_limit};
    end
  end

endmodule

### hdl/vspi_ctrl.sv
// Controller state machine: accept, scan sequencing and result hand-off
`timescale 1ns / 1ps
module vspi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  vspi_pkg::vspi_stat_t stat,
  output vspi_pkg::vspi_cmd_t  cmd
);
  import vspi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_next    = state;
    cmd.write     = 1'b0;
    cmd.load      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.emit      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (stat.is_update) begin
            cmd.load   = 1'b1;
            state_next = stat.needs_select ? S_SCAN : S_EMIT;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hdl/vspi_dp.sv
// Datapath: entry tables, priority scan, decision and result register
`timescale 1ns / 1ps
module vspi_dp #(
  parameter int NUM_ENTRIES   = vspi_pkg::NUM_ENTRIES_DEF,
  parameter int PRIORITY_BITS = vspi_pkg::PRIORITY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [vspi_pkg::IN_W-1:0]       s_axis_tdata,
  input  logic [vspi_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [vspi_pkg::OUT_W-1:0]      m_axis_tdata,
  output logic [vspi_pkg::STATUS_W-1:0]   m_axis_tuser,
  input  logic [vspi_pkg::MASK_W-1:0]     inject_limit,
  input  logic [vspi_pkg::BASE_W-1:0]     base_interrupt_id,
  input  vspi_pkg::vspi_cmd_t             cmd,
  output vspi_pkg::vspi_stat_t            stat
);
  import vspi_pkg::*;

  localparam int CW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  logic [INDEX_W-1:0]       in_index;
  logic [VALUE_W-1:0]       in_value;
  logic                     in_primary;
  logic                     in_lr_empty;
  logic                     index_ok;
  logic [CW-1:0]            wr_sel;

  logic [NUM_ENTRIES-1:0]   pending_bits;
  logic [NUM_ENTRIES-1:0]   enable_bits;
  logic [PRIORITY_BITS-1:0] priority_table [NUM_ENTRIES];
  logic                     asserting_flag;

  logic                     it_select;
  logic                     it_inject_ok;
  logic                     it_event_busy;
  logic                     it_send_ok;

  logic [CW-1:0]            cnt;
  logic [MASK_W-1:0]        best;
  logic [CW-1:0]            pick;
  logic                     found;
  logic [MASK_W-1:0]        cur_prio;
  logic                     cur_cand;

  logic [STATUS_W-1:0]      res_status;
  logic [ID_W-1:0]          res_id;
  logic                     clear_pick;
  logic                     set_flag;

  assign in_index    = s_axis_tdata[4:0];
  assign in_value    = s_axis_tdata[12:5];
  assign in_primary  = s_axis_tdata[13];
  assign in_lr_empty = s_axis_tdata[14];
  assign index_ok    = (32'(in_index) < NUM_ENTRIES);
  assign wr_sel      = in_index[CW-1:0];

  assign stat.is_update    = (s_axis_tuser == MODE_UPDATE);
  assign stat.needs_select = asserting_flag ? (in_lr_empty && in_primary) : in_primary;
  assign stat.scan_last    = (cnt == '0);
  assign stat.out_free     = !m_axis_tvalid || m_axis_tready;

  assign cur_prio = MASK_W'(priority_table[cnt]);
  assign cur_cand = pending_bits[cnt] && enable_bits[cnt];

  always_comb begin
    res_status = ST_NONE;
    res_id     = '0;
    clear_pick = 1'b0;
    set_flag   = 1'b0;
    if (it_select) begin
      if (found) begin
        res_id = ID_W'(base_interrupt_id) + ID_W'(pick);
        if (it_inject_ok) begin
          res_status = ST_INJECTED;
          clear_pick = 1'b1;
        end else begin
          res_status = ST_FAILED;
        end
      end
    end else if (!asserting_flag) begin
      if (it_event_busy) begin
        res_status = ST_BUSY;
      end else if (it_send_ok) begin
        res_status = ST_FORWARDED;
        set_flag   = 1'b1;
      end else begin
        res_status = ST_FAILED;
      end
    end
  end

  // entry state and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits   <= '0;
      enable_bits    <= '0;
      asserting_flag <= 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        priority_table[i] <= '0;
      end
    end else begin
      if (cmd.write && index_ok) begin
        case (s_axis_tuser)
          MODE_WR_PRIO:    priority_table[wr_sel] <= in_value[PRIORITY_BITS-1:0];
          MODE_WR_PENDING: pending_bits[wr_sel]   <= in_value[0];
          MODE_WR_ENABLE:  enable_bits[wr_sel]    <= in_value[0];
          default: begin
          end
        endcase
      end
      if (cmd.emit && clear_pick) begin
        pending_bits[pick] <= 1'b0;
      end
      if (cmd.emit && set_flag) begin
        asserting_flag <= 1'b1;
      end
    end
  end

  // latched item and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_select     <= stat.needs_select;
      it_inject_ok  <= s_axis_tdata[15];
      it_event_busy <= s_axis_tdata[16];
      it_send_ok    <= s_axis_tdata[17];
      cnt           <= CW'(NUM_ENTRIES - 1);
      best          <= inject_limit;
      pick          <= '0;
      found         <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!stat.scan_last) begin
        cnt <= cnt - 1'b1;
      end
      if (cur_cand && (cur_prio < best)) begin
        best  <= cur_prio;
        pick  <= cnt;
        found <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_axis_tdata <= {{(OUT_W-ID_W){1'b0}}, res_id};
      m_axis_tuser <= res_status;
    end
  end

endmodule

### tb/virtual_spi_priority_injector_tb.sv
// Self-checking testbench for the virtual shared-interrupt priority injector
`timescale 1ns / 1ps
module virtual_spi_priority_injector_tb;
  import vspi_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int SETTLE_CYCLES   = 2 * (NUM_ENTRIES_DEF + 2);
  localparam int LONG_HOLD       = 400;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PRINT_CAP       = 40;
  localparam int TAIL_START      = 18;

  localparam logic [4:0] F_PRIM  = 5'b00001;
  localparam logic [4:0] F_LRE   = 5'b00010;
  localparam logic [4:0] F_IOK   = 5'b00100;
  localparam logic [4:0] F_EBUSY = 5'b01000;
  localparam logic [4:0] F_SOK   = 5'b10000;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic               prim;
    logic               lre;
    logic               iok;
    logic               ebusy;
    logic               sok;
  } irq_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
  } outcome_t;

  typedef struct {
    irq_cmd_t            cmd;
    bit                  typed;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic [MODE_W-1:0]   s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [NUM_ENTRIES_DEF-1:0] pending_shadow;
  logic [NUM_ENTRIES_DEF-1:0] enable_shadow;
  logic [VALUE_W-1:0]         prio_shadow [NUM_ENTRIES_DEF];
  logic                       asserting_shadow;
  logic [MASK_W-1:0]          mask_shadow;
  logic [BASE_W-1:0]          base_shadow;

  outcome_t  awaited_outcomes [$];
  stim_row_t directed_rows [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        idle_on = 1'b1;
  bit        long_hold_req = 1'b0;

  virtual_spi_priority_injector dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  function automatic outcome_t pick_winner(logic accept);
    outcome_t            r;
    logic [NUM_ENTRIES_DEF-1:0] cand;
    logic [MASK_W-1:0]   best;
    int                  pick;
    cand = pending_shadow & enable_shadow;
    best = mask_shadow;
    pick = 0;
    r.status = ST_NONE;
    r.id = '0;
    for (int i = NUM_ENTRIES_DEF - 1; i >= 0; i--) begin
      if (cand[i] && prio_shadow[i] < best) begin
        best = prio_shadow[i];
        pick = i;
      end
    end
    if (best < mask_shadow) begin
      r.id = ID_W'(base_shadow) + ID_W'(pick);
      if (accept) begin
        pending_shadow[pick] = 1'b0;
        r.status = ST_INJECTED;
      end else begin
        r.status = ST_FAILED;
      end
    end
    return r;
  endfunction

  function automatic outcome_t resolve_command(irq_cmd_t c);
    outcome_t r;
    r.status = ST_NONE;
    r.id = '0;
    case (c.mode)
      MODE_WR_PRIO: prio_shadow[c.index] = c.value;
      MODE_WR_PENDING: pending_shadow[c.index] = c.value[0];
      MODE_WR_ENABLE: enable_shadow[c.index] = c.value[0];
      default: begin
        if (!asserting_shadow) begin
          if (c.prim) begin
            r = pick_winner(c.iok);
          end else if (c.ebusy) begin
            r.status = ST_BUSY;
          end else if (c.sok) begin
            asserting_shadow = 1'b1;
            r.status = ST_FORWARDED;
          end else begin
            r.status = ST_FAILED;
          end
        end else if (c.lre && c.prim) begin
          r = pick_winner(c.iok);
        end
      end
    endcase
    return r;
  endfunction

  function automatic stim_row_t row(logic [MODE_W-1:0] mode, int index, int value,
                                    logic [4:0] flags, bit typed,
                                    logic [STATUS_W-1:0] status, int id);
    stim_row_t s;
    s.cmd.mode  = mode;
    s.cmd.index = INDEX_W'(index);
    s.cmd.value = VALUE_W'(value);
    s.cmd.prim  = flags[0];
    s.cmd.lre   = flags[1];
    s.cmd.iok   = flags[2];
    s.cmd.ebusy = flags[3];
    s.cmd.sok   = flags[4];
    s.typed     = typed;
    s.status    = status;
    s.id        = ID_W'(id);
    return s;
  endfunction

  function automatic irq_cmd_t random_command(bit allow_forward);
    irq_cmd_t c;
    int       pick;
    c.index = INDEX_W'($urandom_range(0, NUM_ENTRIES_DEF - 1));
    c.value = VALUE_W'($urandom);
    c.prim  = ($urandom_range(0, 3) != 0);
    c.lre   = ($urandom_range(0, 3) != 0);
    c.iok   = ($urandom_range(0, 3) != 0);
    c.ebusy = 1'($urandom);
    c.sok   = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c.mode = MODE_WR_PRIO;
      if ($urandom_range(0, 3) != 0) c.value = VALUE_W'($urandom_range(0, 7));
    end else if (pick < 45) begin
      c.mode = MODE_WR_PENDING;
      c.value[0] = ($urandom_range(0, 9) < 7);
    end else if (pick < 65) begin
      c.mode = MODE_WR_ENABLE;
      c.value[0] = ($urandom_range(0, 9) < 8);
    end else begin
      c.mode = MODE_UPDATE;
    end
    if (!allow_forward && !c.prim && !c.ebusy) c.sok = 1'b0;
    return c;
  endfunction

  task automatic send_command(irq_cmd_t c, bit typed, logic [STATUS_W-1:0] status,
                              logic [ID_W-1:0] id);
    outcome_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = c.mode;
    s_axis_tdata  = {6'd0, c.sok, c.ebusy, c.iok, c.lre, c.prim, c.value, c.index};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = resolve_command(c);
    if (typed) begin
      r.status = status;
      r.id = id;
    end
    if (c.mode == MODE_UPDATE) awaited_outcomes.push_back(r);
    @(negedge clk);
  endtask

  task automatic apb_access(bit wr, logic [0:0] reg_sel, logic [DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {reg_sel, 2'b00};
    pwdata  = wr ? value : '0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (!wr && prdata != value) report_mismatch("register read", prdata, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_registers(int mask, int base);
    apb_access(1'b1, REG_INJECT_LIMIT, DATA_W'(mask));
    apb_access(1'b1, REG_BASE_ID, DATA_W'(base));
    mask_shadow = MASK_W'(mask);
    base_shadow = BASE_W'(base);
    apb_access(1'b0, REG_INJECT_LIMIT, DATA_W'(mask));
    apb_access(1'b0, REG_BASE_ID, DATA_W'(base));
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (awaited_outcomes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic walk_rows(int first, int last);
    for (int k = first; k < last; k++) begin
      send_command(directed_rows[k].cmd, directed_rows[k].typed,
                   directed_rows[k].status, directed_rows[k].id);
    end
  endtask

  task automatic run_phase(int phase, int mask, int base);
    settle();
    set_registers(mask, base);
    idle_on = (phase != PHASES - 1);
    if (phase == 2) long_hold_req = 1'b1;
    for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
      send_command(random_command(phase >= PHASES / 2), 1'b0, ST_NONE, '0);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("unexpected result status", m_axis_tuser, -1);
      end else begin
        want = awaited_outcomes.pop_front();
        if (m_axis_tuser != want.status) report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[ID_W-1:0] != want.id) begin
          report_mismatch("interrupt_id", m_axis_tdata[ID_W-1:0], want.id);
        end
        if (m_axis_tdata[OUT_W-1:ID_W] != '0) begin
          report_mismatch("tdata padding", m_axis_tdata[OUT_W-1:ID_W], 0);
        end
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        m_axis_tready = 1'b0;
        for (int hold = 0; hold < LONG_HOLD; hold++) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    int phase_mask [PHASES];
    int phase_base [PHASES];
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_WR_PRIO;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    pending_shadow   = '0;
    enable_shadow    = '0;
    asserting_shadow = 1'b0;
    mask_shadow      = MASK_RESET;
    base_shadow      = BASE_RESET;
    foreach (prio_shadow[i]) prio_shadow[i] = '0;
    phase_mask = '{255, 0, 4, $urandom_range(1, 254),
                   255, 1, $urandom_range(0, 255), $urandom_range(0, 255)};
    phase_base = '{32, 0, 1019, $urandom_range(0, 1019),
                   1019, $urandom_range(0, 1019), 0, $urandom_range(0, 1019)};

    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_PRIM | F_LRE | F_IOK, 1, ST_NONE, 0));
    directed_rows.push_back(row(MODE_WR_PRIO, 31, 255, 5'b0, 0, ST_NONE, 0));
    directed_rows.push_back(row(MODE_WR_PENDING, 31, 255, 5'b0, 0, ST_NONE, 0));
    directed_rows.push_back(row(MODE_WR_ENABLE, 31, 1, 5'b0, 0, ST_NONE, 0));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_PRIM | F_IOK, 1, ST_NONE, 0));
    directed_rows.push_back(row(MODE_WR_PRIO, 0, 0, 5'b0, 0, ST_NONE, 0));
    directed_rows.push_back(row(MODE_WR_PENDING, 0, 8'hFE, 5'b0, 0, ST_NONE, 0));
    directed_rows.push_back(row(MODE_WR_ENABLE, 0, 1, 5'b0, 0, ST_NONE, 0));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_PRIM | F_IOK, 1, ST_NONE, 0));
    directed_rows.push_back(row(MODE_WR_PENDING, 0, 1, 5'b0, 0, ST_NONE, 0));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_PRIM, 1, ST_FAILED, 32));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_PRIM | F_IOK, 1, ST_INJECTED, 32));
    directed_rows.push_back(row(MODE_WR_PRIO, 31, 0, 5'b0, 0, ST_NONE, 0));
    directed_rows.push_back(row(MODE_WR_PENDING, 0, 1, 5'b0, 0, ST_NONE, 0));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_PRIM | F_IOK, 1, ST_INJECTED, 63));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_PRIM | F_IOK, 1, ST_INJECTED, 32));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_EBUSY | F_SOK, 1, ST_BUSY, 0));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, 5'b0, 1, ST_FAILED, 0));
    directed_rows.push_back(row(MODE_WR_PENDING, 31, 1, 5'b0, 0, ST_NONE, 0));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_SOK | F_LRE, 1, ST_FORWARDED, 0));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_PRIM | F_IOK, 1, ST_NONE, 0));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_LRE | F_IOK | F_SOK, 1, ST_NONE, 0));
    directed_rows.push_back(row(MODE_UPDATE, 0, 0, F_PRIM | F_LRE | F_IOK, 0, ST_NONE, 0));

    repeat (8) @(negedge clk);
    rst = 1'b0;

    walk_rows(0, TAIL_START);
    for (int p = 0; p < PHASES / 2; p++) run_phase(p, phase_mask[p], phase_base[p]);
    settle();
    walk_rows(TAIL_START, directed_rows.size());
    for (int p = PHASES / 2; p < PHASES; p++) run_phase(p, phase_mask[p], phase_base[p]);
    settle();

    if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
